/* src/ewmc_pkg.sv */
package ewmc_pkg;

  localparam int WFRAC = 24;
  localparam int SMP_W = 32;

  localparam logic [31:0] W_ONE   = 32'(64'd1 << WFRAC);
  localparam logic [31:0] W_MAX   = '1;
  localparam logic [24:0] A_ONE   = 25'(64'd1 << WFRAC);
  localparam logic [24:0] ALPHA_LO = 25'd65536;
  localparam logic [24:0] ALPHA_HI = 25'd16777216;
  localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

  // quotient bit counts of the shared divider
  localparam logic [6:0] QB_W = 7'd32;
  localparam logic [6:0] QB_F = 7'd33;
  localparam logic [6:0] QB_R = 7'd64;

  typedef enum logic [2:0] {
    CFG_ALPHA   = 3'd0,
    CFG_MIN_OBS = 3'd1,
    CFG_ADJUST  = 3'd2,
    CFG_IGNORE  = 3'd3,
    CFG_BIASED  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [24:0] alpha;
    logic [15:0] min_obs;
    logic        adjust;
    logic        ignore;
    logic        biased;
  } cfg_t;

  typedef struct packed {
    logic                    first;
    logic signed [SMP_W-1:0] x_sample;
    logic                    x_present;
    logic signed [SMP_W-1:0] y_sample;
    logic                    y_present;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] covariance;
    logic               covariance_valid;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [64:0] rem0;
    logic [63:0] bits;
    logic [63:0] dvsr;
    logic [6:0]  count;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  typedef enum logic [1:0] {
    UM_CA,
    UM_CB,
    UM_RATIO
  } um_sel_t;

  typedef enum logic [5:0] {
    S_IDLE, S_W1, S_W2, S_W3, S_W4, S_W5,
    S_FS, S_FW, S_MXS, S_MXD, S_MXW, S_MYS, S_MYD, S_MYW,
    S_PA, S_PB, S_PC, S_CA,
    S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_UR,
    S_WA, S_WB, S_N1, S_N2, S_N3, S_N4, S_N5,
    S_RES, S_B1, S_B2, S_B3, S_B4, S_FIN
  } seq_state_t;

  // weight product rounding, half up, saturating
  function automatic logic [31:0] w_round(input logic [65:0] p);
    logic [65:0] s;
    s = p + 66'(64'd1 << (WFRAC - 1));
    if (|s[65:WFRAC+32]) return W_MAX;
    return s[WFRAC+31:WFRAC];
  endfunction

  function automatic logic [31:0] w_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? W_MAX : s[31:0];
  endfunction

  function automatic logic [63:0] mag_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, MAG_CAP}) ? MAG_CAP : s[63:0];
  endfunction

  function automatic logic [63:0] to_mag(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (m[63]) return neg ? S64_MIN : S64_MAX;
    return neg ? (~m + 64'd1) : m;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

endpackage

/* src/ewmc_if.sv */
interface ewmc_in_if;
  logic               valid;
  logic               ready;
  logic               first;
  logic signed [31:0] x_sample;
  logic               x_present;
  logic signed [31:0] y_sample;
  logic               y_present;

  modport source (output valid, first, x_sample, x_present, y_sample, y_present,
                  input ready);
  modport sink (input valid, first, x_sample, x_present, y_sample, y_present,
                output ready);
endinterface

interface ewmc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] covariance;
  logic               covariance_valid;

  modport source (output valid, covariance, covariance_valid, input ready);
  modport sink (input valid, covariance, covariance_valid, output ready);
endinterface

/* src/ewmc_mul.sv */
module ewmc_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] prod
);
  logic [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 66'(a) * 66'(b);
  end

  assign prod = prod_r;
endmodule

/* src/ewmc_div.sv */
module ewmc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ewmc_pkg::div_req_t  req,
  output ewmc_pkg::div_stat_t st,
  output logic [63:0]         quot
);
  import ewmc_pkg::*;

  logic        run_r, done_r, ovf_r;
  logic [6:0]  cnt_r;
  logic [64:0] rem_r;
  logic [63:0] sh_r, q_r, dvsr_r;
  logic [64:0] trial;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r[63:0], sh_r[63]};
  assign ge    = trial >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 7'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem0;
      sh_r   <= req.bits;
      dvsr_r <= req.dvsr;
      cnt_r  <= req.count;
      q_r    <= '0;
      ovf_r  <= req.rem0 >= {1'b0, req.dvsr};
    end else if (run_r) begin
      rem_r <= ge ? (trial - {1'b0, dvsr_r}) : trial;
      q_r   <= {q_r[62:0], ge};
      sh_r  <= {sh_r[62:0], 1'b0};
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign st.done = done_r;
  assign st.ovf  = ovf_r;
  assign quot    = q_r;
endmodule

/* src/ewmc_seq.sv */
module ewmc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  ewmc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  ewmc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ewmc_pkg::out_item_t out_item
);
  import ewmc_pkg::*;

  seq_state_t state_r, state_nxt;

  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic               obs_r, obs_nxt;
  logic [24:0]        owf_r, owf_nxt, nw_r, nw_nxt;
  logic signed [31:0] mean_x_r, mean_x_nxt, mean_y_r, mean_y_nxt;
  logic signed [31:0] omx_r, omx_nxt, omy_r, omy_nxt;
  logic               have_mean_r, have_mean_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic [63:0]        cov_r, cov_nxt, ca_r, ca_nxt, cb_r, cb_nxt, ua_r, ua_nxt;
  logic [63:0]        res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [31:0]        ws_r, ws_nxt, wss_r, wss_nxt, pw_r, pw_nxt, t_r, t_nxt;
  logic [32:0]        den_r, den_nxt, f_r, f_nxt;
  logic [63:0]        num_r, num_nxt, bden_r, bden_nxt;
  logic [63:0]        um_m_r, um_m_nxt, um_rat_r, um_rat_nxt, um_acc_r, um_acc_nxt;
  logic [63:0]        um_res_r, um_res_nxt;
  logic               um_neg_r, um_neg_nxt;
  um_sel_t            um_sel_r, um_sel_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic        in_acc, obs_in, hm, out_free;
  logic [15:0] cnt_base;
  logic [24:0] alpha_c;
  logic [32:0] dxa, dya, dxb, dyb, mxa, mya, mxb, myb;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [95:0] div_num;
  logic [6:0]  div_k;
  logic [63:0] div_dvsr, quot, s2;
  logic        div_start;
  logic [31:0] div_q32;
  div_req_t    dreq;
  div_stat_t   dst;

  ewmc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  ewmc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .st(dst), .quot(quot));

  assign in_ready = state_r == S_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign obs_in   = in_item.x_present && in_item.y_present;
  assign hm       = in_item.first ? 1'b0 : have_mean_r;
  assign cnt_base = in_item.first ? 16'd0 : cnt_r;
  assign out_free = !out_valid_r || out_ready;
  assign s2       = 64'(wss_r) << WFRAC;
  assign div_q32  = dst.ovf ? W_MAX : quot[31:0];

  assign alpha_c = (cfg.alpha < ALPHA_LO) ? ALPHA_LO :
                   (cfg.alpha > ALPHA_HI) ? ALPHA_HI : cfg.alpha;

  // mean shifts and sample residuals
  assign dxa = {omx_r[31], omx_r} - {mean_x_r[31], mean_x_r};
  assign dya = {omy_r[31], omy_r} - {mean_y_r[31], mean_y_r};
  assign dxb = {x_r[31], x_r} - {mean_x_r[31], mean_x_r};
  assign dyb = {y_r[31], y_r} - {mean_y_r[31], mean_y_r};
  assign mxa = dxa[32] ? (~dxa + 33'd1) : dxa;
  assign mya = dya[32] ? (~dya + 33'd1) : dya;
  assign mxb = dxb[32] ? (~dxb + 33'd1) : dxb;
  assign myb = dyb[32] ? (~dyb + 33'd1) : dyb;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_W1:  begin mul_a = 33'(owf_r);            mul_b = 33'(owf_r); end
      S_W2:  begin mul_a = 33'(ws_r);             mul_b = 33'(owf_r); end
      S_W3:  begin mul_a = 33'(wss_r);            mul_b = 33'(t_r); end
      S_W4:  begin mul_a = 33'(pw_r);             mul_b = 33'(owf_r); end
      S_MXS: begin mul_a = mxb;                   mul_b = 33'(nw_r); end
      S_MYS: begin mul_a = myb;                   mul_b = 33'(nw_r); end
      S_PA:  begin mul_a = mxa;                   mul_b = mya; end
      S_PB:  begin mul_a = mxb;                   mul_b = myb; end
      S_U0:  begin mul_a = 33'(um_m_r[63:32]);    mul_b = 33'(um_rat_r[63:32]); end
      S_U1:  begin mul_a = 33'(um_m_r[63:32]);    mul_b = 33'(um_rat_r[31:0]); end
      S_U2:  begin mul_a = 33'(um_m_r[31:0]);     mul_b = 33'(um_rat_r[63:32]); end
      S_U3:  begin mul_a = 33'(um_m_r[31:0]);     mul_b = 33'(um_rat_r[31:0]); end
      S_WA:  begin mul_a = 33'(nw_r);             mul_b = 33'(nw_r); end
      S_N1:  begin mul_a = 33'(pw_r);             mul_b = 33'(pw_r); end
      S_RES: begin mul_a = 33'(ws_r);             mul_b = 33'(ws_r); end
      default: ;
    endcase
  end

  // shared divider request
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_k     = QB_W;
    div_dvsr  = '0;
    case (state_r)
      S_FS: begin
        div_start = 1'b1;
        div_num   = (96'(nw_r) << 32) + 96'(den_r >> 1);
        div_k     = QB_F;
        div_dvsr  = 64'(den_r);
      end
      S_MXD, S_MYD: begin
        div_start = 1'b1;
        div_num   = 96'(prod) + 96'(den_r >> 1);
        div_k     = QB_F;
        div_dvsr  = 64'(den_r);
      end
      S_N2: begin
        div_start = 1'b1;
        div_num   = (96'(ws_r) << WFRAC) + 96'(pw_r >> 1);
        div_dvsr  = 64'(pw_r);
      end
      S_N4: begin
        div_start = 1'b1;
        div_num   = (96'(wss_r) << WFRAC) + 96'(t_r >> 1);
        div_dvsr  = 64'(t_r);
      end
      S_B3: begin
        div_start = 1'b1;
        div_num   = {num_r, 32'd0};
        div_k     = QB_R;
        div_dvsr  = bden_r;
      end
      default: ;
    endcase
    dreq.start = div_start;
    dreq.dvsr  = div_dvsr;
    dreq.count = div_k;
    case (div_k)
      QB_F: begin
        dreq.rem0 = 65'(div_num[95:33]);
        dreq.bits = {div_num[32:0], 31'd0};
      end
      QB_R: begin
        dreq.rem0 = 65'(div_num[95:64]);
        dreq.bits = div_num[63:0];
      end
      default: begin
        dreq.rem0 = 65'(div_num[95:32]);
        dreq.bits = {div_num[31:0], 32'd0};
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        state_nxt = (hm && (obs_in || !cfg.ignore)) ? S_W1 : S_RES;
      end
      S_W1:  state_nxt = S_W2;
      S_W2:  state_nxt = S_W3;
      S_W3:  state_nxt = S_W4;
      S_W4:  state_nxt = S_W5;
      S_W5:  state_nxt = obs_r ? S_FS : S_RES;
      S_FS:  state_nxt = S_FW;
      S_FW:  if (dst.done) state_nxt = S_MXS;
      S_MXS: state_nxt = S_MXD;
      S_MXD: state_nxt = S_MXW;
      S_MXW: if (dst.done) state_nxt = S_MYS;
      S_MYS: state_nxt = S_MYD;
      S_MYD: state_nxt = S_MYW;
      S_MYW: if (dst.done) state_nxt = S_PA;
      S_PA:  state_nxt = S_PB;
      S_PB:  state_nxt = S_PC;
      S_PC:  state_nxt = S_CA;
      S_CA:  state_nxt = S_U0;
      S_U0:  state_nxt = S_U1;
      S_U1:  state_nxt = S_U2;
      S_U2:  state_nxt = S_U3;
      S_U3:  state_nxt = S_U4;
      S_U4:  state_nxt = S_U5;
      S_U5:  state_nxt = S_UR;
      S_UR: begin
        unique case (um_sel_r)
          UM_CA:   state_nxt = S_U0;
          UM_CB:   state_nxt = S_WA;
          default: state_nxt = S_FIN;
        endcase
      end
      S_WA:  state_nxt = S_WB;
      S_WB:  state_nxt = cfg.adjust ? S_RES : S_N1;
      S_N1:  state_nxt = S_N2;
      S_N2:  state_nxt = S_N3;
      S_N3:  if (dst.done) state_nxt = S_N4;
      S_N4:  state_nxt = S_N5;
      S_N5:  if (dst.done) state_nxt = S_RES;
      S_RES: state_nxt = (cnt_r < cfg.min_obs || cfg.biased) ? S_FIN : S_B1;
      S_B1:  state_nxt = S_B2;
      S_B2:  state_nxt = (num_r > s2) ? S_B3 : S_FIN;
      S_B3:  state_nxt = S_B4;
      S_B4:  if (dst.done) state_nxt = S_U0;
      S_FIN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    x_nxt = x_r;            y_nxt = y_r;            obs_nxt = obs_r;
    owf_nxt = owf_r;        nw_nxt = nw_r;
    mean_x_nxt = mean_x_r;  mean_y_nxt = mean_y_r;
    omx_nxt = omx_r;        omy_nxt = omy_r;
    have_mean_nxt = have_mean_r;
    cnt_nxt = cnt_r;
    cov_nxt = cov_r;        ca_nxt = ca_r;          cb_nxt = cb_r;      ua_nxt = ua_r;
    res_nxt = res_r;        res_valid_nxt = res_valid_r;
    ws_nxt = ws_r;          wss_nxt = wss_r;        pw_nxt = pw_r;      t_nxt = t_r;
    den_nxt = den_r;        f_nxt = f_r;
    num_nxt = num_r;        bden_nxt = bden_r;
    um_m_nxt = um_m_r;      um_rat_nxt = um_rat_r;  um_acc_nxt = um_acc_r;
    um_res_nxt = um_res_r;  um_neg_nxt = um_neg_r;  um_sel_nxt = um_sel_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: if (in_acc) begin
        x_nxt   = in_item.x_sample;
        y_nxt   = in_item.y_sample;
        obs_nxt = obs_in;
        owf_nxt = A_ONE - alpha_c;
        nw_nxt  = cfg.adjust ? A_ONE : alpha_c;
        cnt_nxt = cnt_base + 16'((obs_in && cnt_base != 16'hffff) ? 1 : 0);
        if (in_item.first) begin
          mean_x_nxt    = '0;
          mean_y_nxt    = '0;
          have_mean_nxt = 1'b0;
          cov_nxt       = '0;
          ws_nxt        = W_ONE;
          wss_nxt       = W_ONE;
          pw_nxt        = W_ONE;
        end
        if (!hm && obs_in) begin
          mean_x_nxt    = in_item.x_sample;
          mean_y_nxt    = in_item.y_sample;
          have_mean_nxt = 1'b1;
        end
      end
      S_W2: t_nxt   = w_round(prod);
      S_W3: ws_nxt  = w_round(prod);
      S_W4: wss_nxt = w_round(prod);
      S_W5: begin
        pw_nxt  = w_round(prod);
        den_nxt = {1'b0, w_round(prod)} + 33'(nw_r);
        omx_nxt = mean_x_r;
        omy_nxt = mean_y_r;
      end
      S_FW: if (dst.done) f_nxt = quot[32:0];
      S_MXW: if (dst.done) begin
        mean_x_nxt = dxb[32] ? (omx_r - quot[31:0]) : (omx_r + quot[31:0]);
      end
      S_MYW: if (dst.done) begin
        mean_y_nxt = dyb[32] ? (omy_r - quot[31:0]) : (omy_r + quot[31:0]);
      end
      S_PB: ca_nxt = from_mag(dxa[32] ^ dya[32], prod[63:0]);
      S_PC: begin
        ca_nxt = sat_add(cov_r, ca_r);
        cb_nxt = from_mag(dxb[32] ^ dyb[32], prod[63:0]);
      end
      S_CA: begin
        um_m_nxt   = to_mag(ca_r);
        um_neg_nxt = ca_r[63];
        um_rat_nxt = 64'(Q32_ONE - f_r);
        um_sel_nxt = UM_CA;
      end
      S_U1: um_acc_nxt = (prod[63:0] >= 64'h8000_0000) ? MAG_CAP : (prod[63:0] << 32);
      S_U2: um_acc_nxt = mag_add(um_acc_r, prod[63:0]);
      S_U3: um_acc_nxt = mag_add(um_acc_r, prod[63:0]);
      S_U4: um_acc_nxt = mag_add(um_acc_r, 64'(prod[63:32]) + 64'(prod[31]));
      S_U5: um_res_nxt = from_mag(um_neg_r, um_acc_r);
      S_UR: begin
        unique case (um_sel_r)
          UM_CA: begin
            ua_nxt     = um_res_r;
            um_m_nxt   = to_mag(cb_r);
            um_neg_nxt = cb_r[63];
            um_rat_nxt = 64'(f_r);
            um_sel_nxt = UM_CB;
          end
          UM_CB: cov_nxt = sat_add(ua_r, um_res_r);
          default: begin
            res_nxt       = um_res_r;
            res_valid_nxt = 1'b1;
          end
        endcase
      end
      S_WA: begin
        ws_nxt = w_add(ws_r, 32'(nw_r));
        pw_nxt = w_add(pw_r, 32'(nw_r));
      end
      S_WB: wss_nxt = w_add(wss_r, w_round(prod));
      S_N2: t_nxt = w_round(prod);
      S_N3: if (dst.done) ws_nxt = div_q32;
      S_N5: if (dst.done) begin
        wss_nxt = div_q32;
        pw_nxt  = W_ONE;
      end
      S_RES: begin
        res_nxt       = '0;
        res_valid_nxt = 1'b0;
        if (cnt_r >= cfg.min_obs && cfg.biased) begin
          res_nxt       = cov_r;
          res_valid_nxt = 1'b1;
        end
      end
      S_B1: num_nxt  = prod[63:0];
      S_B2: bden_nxt = num_r - s2;
      S_B4: if (dst.done) begin
        um_m_nxt   = to_mag(cov_r);
        um_neg_nxt = cov_r[63];
        um_rat_nxt = dst.ovf ? 64'hffff_ffff_ffff_ffff : quot;
        um_sel_nxt = UM_RATIO;
      end
      S_FIN: if (out_free) begin
        out_item_nxt.covariance       = res_r;
        out_item_nxt.covariance_valid = res_valid_r;
        out_valid_nxt                 = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      have_mean_r <= 1'b0;
      cnt_r       <= '0;
      mean_x_r    <= '0;
      mean_y_r    <= '0;
      cov_r       <= '0;
      ws_r        <= W_ONE;
      wss_r       <= W_ONE;
      pw_r        <= W_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_mean_r <= have_mean_nxt;
      cnt_r       <= cnt_nxt;
      mean_x_r    <= mean_x_nxt;
      mean_y_r    <= mean_y_nxt;
      cov_r       <= cov_nxt;
      ws_r        <= ws_nxt;
      wss_r       <= wss_nxt;
      pw_r        <= pw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    obs_r       <= obs_nxt;
    owf_r       <= owf_nxt;
    nw_r        <= nw_nxt;
    omx_r       <= omx_nxt;
    omy_r       <= omy_nxt;
    ca_r        <= ca_nxt;
    cb_r        <= cb_nxt;
    ua_r        <= ua_nxt;
    res_r       <= res_nxt;
    res_valid_r <= res_valid_nxt;
    t_r         <= t_nxt;
    den_r       <= den_nxt;
    f_r         <= f_nxt;
    num_r       <= num_nxt;
    bden_r      <= bden_nxt;
    um_m_r      <= um_m_nxt;
    um_rat_r    <= um_rat_nxt;
    um_acc_r    <= um_acc_nxt;
    um_res_r    <= um_res_nxt;
    um_neg_r    <= um_neg_nxt;
    um_sel_r    <= um_sel_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule

/* src/ewm_covariance.sv */
// Exponentially weighted moving covariance of paired Q16.16 samples. Each input
// transfer gives exactly one result transfer: a saturated Q32.32 covariance and a
// valid flag that is low while fewer than min_obs pairs were observed or while the
// bias-corrected denominator is not positive. Work is done by one multiplier and a
// restoring divider that produces one quotient bit per cycle, under a sequencer;
// the block takes no new item until the current one is finished, while the last
// result can still wait in the output register. The user must write the
// configuration only while the block is idle; the block does not enforce it.
module ewm_covariance (
  input  logic              clk,
  input  logic              rst_n,
  ewmc_in_if.sink           in_if,
  ewmc_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [24:0]       cfg_wdata
);
  import ewmc_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item;
  out_item_t out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha   <= 25'd8388608;
      cfg_r.min_obs <= 16'd1;
      cfg_r.adjust  <= 1'b1;
      cfg_r.ignore  <= 1'b0;
      cfg_r.biased  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA:   cfg_r.alpha   <= cfg_wdata;
        CFG_MIN_OBS: cfg_r.min_obs <= cfg_wdata[15:0];
        CFG_ADJUST:  cfg_r.adjust  <= cfg_wdata[0];
        CFG_IGNORE:  cfg_r.ignore  <= cfg_wdata[0];
        CFG_BIASED:  cfg_r.biased  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_item.first     = in_if.first;
  assign in_item.x_sample  = in_if.x_sample;
  assign in_item.x_present = in_if.x_present;
  assign in_item.y_sample  = in_if.y_sample;
  assign in_item.y_present = in_if.y_present;

  ewmc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_item   (in_item),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_item  (out_item)
  );

  assign out_if.covariance       = out_item.covariance;
  assign out_if.covariance_valid = out_item.covariance_valid;
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ewmc_pkg::*;

  typedef longint unsigned u64;
  typedef longint s64;

  localparam u64 ONE_W   = 64'd1 << 24;
  localparam u64 MAX_W   = 64'hFFFF_FFFF;
  localparam u64 CAP     = 64'h8000_0000_0000_0000;
  localparam int N_PHASE = 10;
  localparam int TAIL    = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [24:0] cfg_wdata;

  ewmc_in_if in_ch ();
  ewmc_out_if out_ch ();

  ewm_covariance dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // register mirror
  logic [24:0] alpha_r;
  logic [15:0] min_obs_r;
  logic adjust_r, ignore_r, biased_r;

  // series state mirror
  s64 mx, my, cov;
  logic seen;
  u64 wsum, wsq, wprior;
  int unsigned nobs;

  in_item_t pending_items[$];
  out_item_t cov_expected[$];
  in_item_t cur;
  int errors;
  int in_gap, out_gap;
  logic quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic u64 wmul(u64 a, u64 b);
    u64 r;
    r = (a * b + (ONE_W >> 1)) >> 24;
    return r > MAX_W ? MAX_W : r;
  endfunction

  function automatic u64 wadd(u64 a, u64 b);
    u64 s;
    s = a + b;
    return s > MAX_W ? MAX_W : s;
  endfunction

  function automatic u64 wdiv(u64 a, u64 d);
    u64 q;
    if (d == 0) return MAX_W;
    q = ((a << 24) + d / 2) / d;
    return q > MAX_W ? MAX_W : q;
  endfunction

  function automatic u64 cap_add(u64 a, u64 b);
    if (a >= CAP || b >= CAP || a >= CAP - b) return CAP;
    return a + b;
  endfunction

  function automatic u64 magof(s64 v);
    return v < 0 ? 64'd0 - u64'(v) : u64'(v);
  endfunction

  function automatic s64 signed_of(logic neg, u64 m);
    if (neg) return m >= CAP ? s64'(CAP) : s64'(64'd0 - m);
    return m >= CAP ? s64'(CAP - 1) : s64'(m);
  endfunction

  // round(m * r / 2^32), magnitude capped at 2^63
  function automatic u64 scale_q32(u64 m, u64 r);
    u64 mh, ml, rh, rl, t, acc, x, lo;
    mh = m >> 32;
    ml = m & MAX_W;
    rh = r >> 32;
    rl = r & MAX_W;
    t = mh * rh;
    if (t >= 64'h8000_0000) return CAP;
    acc = t << 32;
    acc = cap_add(acc, mh * rl);
    x = ml * rh;
    acc = cap_add(acc, x > CAP ? CAP : x);
    lo = ml * rl;
    lo = (lo >> 32) + ((lo >> 31) & 64'd1);
    return cap_add(acc, lo);
  endfunction

  function automatic s64 sscale_q32(s64 v, u64 r);
    return signed_of(v < 0, scale_q32(magof(v), r));
  endfunction

  function automatic s64 add_sat(s64 a, s64 b);
    s64 s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? s64'(CAP) : s64'(CAP - 1);
    return s;
  endfunction

  function automatic s64 dev_product(s64 dx, s64 dy);
    return signed_of((dx < 0) != (dy < 0), magof(dx) * magof(dy));
  endfunction

  function automatic s64 move_mean(s64 old, s64 smp, u64 nw, u64 den);
    u64 m, q;
    m = magof(smp - old);
    q = (m * nw + den / 2) / den;
    return (smp - old) < 0 ? old - s64'(q) : old + s64'(q);
  endfunction

  function automatic void clear_series();
    mx = 0;
    my = 0;
    seen = 1'b0;
    cov = 0;
    wsum = ONE_W;
    wsq = ONE_W;
    wprior = ONE_W;
    nobs = 0;
  endfunction

  function automatic out_item_t predict_cov(in_item_t it);
    out_item_t o;
    u64 a, owf, nw, den, f, num, s2, dd, q, r, ratio;
    s64 x, y, omx, omy, ca, cb;
    logic is_obs, carry;
    x = s64'(it.x_sample);
    y = s64'(it.y_sample);
    is_obs = it.x_present && it.y_present;
    o.covariance = '0;
    o.covariance_valid = 1'b0;
    if (it.first) clear_series();
    a = u64'(alpha_r);
    if (a < 65536) a = 65536;
    if (a > ONE_W) a = ONE_W;
    owf = ONE_W - a;
    nw = adjust_r ? ONE_W : a;
    if (is_obs && nobs < 65535) nobs++;
    if (seen) begin
      if (is_obs || !ignore_r) begin
        wsum = wmul(wsum, owf);
        wsq = wmul(wsq, wmul(owf, owf));
        wprior = wmul(wprior, owf);
        if (is_obs) begin
          omx = mx;
          omy = my;
          den = wprior + nw;
          f = ((nw << 32) + den / 2) / den;
          if (mx != x) mx = move_mean(omx, x, nw, den);
          if (my != y) my = move_mean(omy, y, nw, den);
          ca = add_sat(cov, dev_product(omx - mx, omy - my));
          cb = dev_product(x - mx, y - my);
          cov = add_sat(sscale_q32(ca, (64'd1 << 32) - f), sscale_q32(cb, f));
          wsum = wadd(wsum, nw);
          wsq = wadd(wsq, wmul(nw, nw));
          wprior = wadd(wprior, nw);
          if (!adjust_r) begin
            wsum = wdiv(wsum, wprior);
            wsq = wdiv(wsq, wmul(wprior, wprior));
            wprior = ONE_W;
          end
        end
      end
    end else if (is_obs) begin
      mx = x;
      my = y;
      seen = 1'b1;
    end
    if (nobs >= min_obs_r) begin
      if (biased_r) begin
        o.covariance = cov;
        o.covariance_valid = 1'b1;
      end else begin
        num = wsum * wsum;
        s2 = wsq << 24;
        if (num > s2) begin
          dd = num - s2;
          q = num / dd;
          r = num % dd;
          if (q >> 32) begin
            ratio = '1;
          end else begin
            for (int i = 0; i < 32; i++) begin
              carry = r[63];
              r = r << 1;
              q = q << 1;
              if (carry || r >= dd) begin
                r = r - dd;
                q = q | 64'd1;
              end
            end
            ratio = q;
          end
          o.covariance = sscale_q32(cov, ratio);
          o.covariance_valid = 1'b1;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) cov_expected.push_back(predict_cov(cur));
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.first <= cur.first;
        in_ch.x_sample <= cur.x_sample;
        in_ch.x_present <= cur.x_present;
        in_ch.y_sample <= cur.y_sample;
        in_ch.y_present <= cur.y_present;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cov_expected.size() == 0) begin
          errors++;
          $display("unexpected result transfer");
        end else begin
          if (out_ch.covariance_valid !== cov_expected[0].covariance_valid)
            report_mismatch("covariance_valid", 64'(out_ch.covariance_valid),
                            64'(cov_expected[0].covariance_valid));
          if (out_ch.covariance !== cov_expected[0].covariance)
            report_mismatch("covariance", out_ch.covariance, cov_expected[0].covariance);
          void'(cov_expected.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [24:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ALPHA:   alpha_r = val;
      CFG_MIN_OBS: min_obs_r = val[15:0];
      CFG_ADJUST:  adjust_r = val[0];
      CFG_IGNORE:  ignore_r = val[0];
      CFG_BIASED:  biased_r = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || cov_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  task automatic push(logic f, logic [31:0] x, logic xp, logic [31:0] y, logic yp);
    in_item_t it;
    it.first = f;
    it.x_sample = x;
    it.x_present = xp;
    it.y_sample = y;
    it.y_present = yp;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [24:0] alpha_pick[4];
    errors = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.first = 1'b0;
    in_ch.x_sample = '0;
    in_ch.x_present = 1'b0;
    in_ch.y_sample = '0;
    in_ch.y_present = 1'b0;
    out_ch.ready = 1'b0;
    alpha_r = 25'd8388608;
    min_obs_r = 16'd1;
    adjust_r = 1'b1;
    ignore_r = 1'b0;
    biased_r = 1'b0;
    clear_series();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: missing before any mean, extremes, first flag mid-series
    push(1'b0, 32'h0001_0000, 1'b1, 32'h0, 1'b0);
    push(1'b0, 32'h0, 1'b0, 32'h0002_0000, 1'b1);
    push(1'b0, 32'h0001_0000, 1'b1, 32'h0002_0000, 1'b1);
    push(1'b0, 32'h0003_0000, 1'b1, 32'hffff_0000, 1'b1);
    push(1'b0, 32'h0, 1'b0, 32'h0, 1'b0);
    push(1'b0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b1);
    push(1'b0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1);
    push(1'b0, 32'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b1);
    push(1'b0, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b1);
    push(1'b1, 32'h0, 1'b1, 32'h0, 1'b1);
    push(1'b0, 32'h0, 1'b1, 32'h0, 1'b1);
    push(1'b1, 32'h0005_0000, 1'b0, 32'h0, 1'b1);
    push(1'b0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1);
    push(1'b0, 32'h0000_0001, 1'b1, 32'hffff_ffff, 1'b1);
    drain();

    alpha_pick[0] = 25'd0;
    alpha_pick[1] = 25'd65536;
    alpha_pick[2] = 25'd16777216;
    alpha_pick[3] = 25'h1ff_ffff;
    for (int p = 0; p < N_PHASE; p++) begin
      write_reg(CFG_ALPHA, (p < 4) ? alpha_pick[p] :
                ($urandom_range(0, 2) == 0 ? alpha_pick[$urandom_range(0, 3)] :
                 25'($urandom_range(65536, 16777216))));
      write_reg(CFG_MIN_OBS, (p == 1) ? 25'd65535 : (p == 2) ? 25'd0 :
                25'($urandom_range(0, 6)));
      write_reg(CFG_ADJUST, 25'(p < 4 ? p[0] : $urandom_range(0, 1)));
      write_reg(CFG_IGNORE, 25'(p < 4 ? p[1] : $urandom_range(0, 1)));
      write_reg(CFG_BIASED, 25'(p < 4 ? (p == 3) : $urandom_range(0, 1)));
      cfg_we <= 1'b0;
      if (p == N_PHASE - 1) quiet = 1'b1;
      push(1'b1, pick_sample(), 1'b1, pick_sample(), 1'b1);
      for (int i = 0; i < 50; i++)
        push($urandom_range(0, 24) == 0, pick_sample(), $urandom_range(0, 7) != 0,
             pick_sample(), $urandom_range(0, 7) != 0);
      drain();
    end

    repeat (TAIL) @(posedge clk);
    if (errors == 0 && cov_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
